// ===== rtl/y2rgb_pkg.sv =====
package y2rgb_pkg;

  // Fixed geometry of one 2x2 block
  localparam int LANES      = 4;
  localparam int REG_ADDR_W = 4;

  // Conversion coefficients, scaled by 256
  localparam logic signed [17:0] COEF_RV = 18'sd351;
  localparam logic signed [17:0] COEF_GV = 18'sd179;
  localparam logic signed [17:0] COEF_GU = 18'sd86;
  localparam logic signed [17:0] COEF_BU = 18'sd444;

  // Channel clamp limit
  localparam logic signed [10:0] CHAN_MAX = 11'sd255;

  // Mask reset values and the matching shifts
  localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
  localparam logic [4:0]  RED_SHIFT_RST   = 5'd16;
  localparam logic [4:0]  GREEN_SHIFT_RST = 5'd8;
  localparam logic [4:0]  BLUE_SHIFT_RST  = 5'd0;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_RED_MASK   = 2'd0,
    REG_GREEN_MASK = 2'd1,
    REG_BLUE_MASK  = 2'd2
  } reg_idx_t;

  // Input item: one block
  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } blk_t;

  // Result item: four packed pixels
  typedef struct packed {
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;
  } px_t;

  // Chroma contributions shared by all lanes, already shifted down by 8
  typedef struct packed {
    logic signed [8:0] r_term;
    logic signed [8:0] g_term;
    logic signed [8:0] b_term;
  } chroma_t;

  // Placement of one channel in the pixel word
  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
  } pack_cfg_t;

endpackage

// ===== rtl/y2rgb_chroma.sv =====
module y2rgb_chroma
  import y2rgb_pkg::*;
(
  input  logic [7:0] chroma_u,
  input  logic [7:0] chroma_v,
  output chroma_t    terms
);

  logic signed [7:0]  du;
  logic signed [7:0]  dv;
  logic signed [17:0] du_x;
  logic signed [17:0] dv_x;
  logic signed [17:0] r_prod;
  logic signed [17:0] g_prod;
  logic signed [17:0] b_prod;

  // Remove the 128 offset: flipping the top bit gives the signed difference
  assign du = $signed({~chroma_u[7], chroma_u[6:0]});
  assign dv = $signed({~chroma_v[7], chroma_v[6:0]});
  assign du_x = $signed({{10{du[7]}}, du});
  assign dv_x = $signed({{10{dv[7]}}, dv});

  // Scale by the coefficients; all products fit in 17 signed bits
  assign r_prod = dv_x * COEF_RV;
  assign g_prod = dv_x * COEF_GV + du_x * COEF_GU;
  assign b_prod = du_x * COEF_BU;

  // Arithmetic shift by 8: keep bits 16..8
  assign terms.r_term = r_prod[16:8];
  assign terms.g_term = g_prod[16:8];
  assign terms.b_term = b_prod[16:8];

endmodule

// ===== rtl/y2rgb_lane.sv =====
module y2rgb_lane
  import y2rgb_pkg::*;
(
  input  logic [7:0]  luma,
  input  chroma_t     terms,
  input  pack_cfg_t   cfg,
  output logic [31:0] pixel
);

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > CHAN_MAX) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] place(input logic [7:0] c, input chan_cfg_t ch);
    return ({24'd0, c} << ch.shift) & ch.mask;
  endfunction

  logic signed [10:0] y_s;
  logic signed [10:0] r_sum;
  logic signed [10:0] g_sum;
  logic signed [10:0] b_sum;

  // Add the shared chroma terms to this lane's luma
  assign y_s   = $signed({3'b000, luma});
  assign r_sum = y_s + $signed({{2{terms.r_term[8]}}, terms.r_term});
  assign g_sum = y_s - $signed({{2{terms.g_term[8]}}, terms.g_term});
  assign b_sum = y_s + $signed({{2{terms.b_term[8]}}, terms.b_term});

  // Clamp, place each channel under its mask and merge
  assign pixel = place(clamp8(r_sum), cfg.red)
               | place(clamp8(g_sum), cfg.green)
               | place(clamp8(b_sum), cfg.blue);

endmodule

// ===== rtl/yuv420_block_to_rgb_pack.sv =====
// Channel   Signals                                  Item
// block     block_valid, block_ready, block          one 2x2 block: four luma, U, V
// pixels    pixels_valid, pixels_ready, pixels       four packed 32-bit pixels
// config    psel, penable, pwrite, paddr, pwdata,    red, green, blue masks
//           prdata, pready
//
// One block per cycle while results are taken; the result is registered twice.
// Stage one forms the shared chroma terms, stage two runs four pixel lanes.
// A full pipeline stalls only while the result register is not taken.
// rst (synchronous) empties the pipeline and loads the default masks.
// Each mask's lowest set bit is found when the mask is written.
module yuv420_block_to_rgb_pack
  import y2rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  block_valid,
  output logic                  block_ready,
  input  blk_t                  block,
  output logic                  pixels_valid,
  input  logic                  pixels_ready,
  output px_t                   pixels,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  function automatic logic [4:0] low_bit(input logic [31:0] m);
    logic [31:0] iso;
    logic [4:0]  pos;
    iso = m & (~m + 32'd1);
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) begin
        pos = pos | 5'(i);
      end
    end
    return pos;
  endfunction

  pack_cfg_t       cfg;
  logic            wr_en;
  reg_idx_t        wr_idx;
  logic [4:0]      wr_shift;

  chroma_t         terms;
  logic            s1_valid;
  logic            s1_en;
  logic            s2_en;
  chroma_t         s1_terms;
  logic [7:0]      s1_luma [LANES];
  logic [31:0]     lane_px [LANES];

  // Register file
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_idx   = reg_idx_t'(paddr[3:2]);
  assign wr_shift = low_bit(pwdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red   <= '{mask: RED_MASK_RST,   shift: RED_SHIFT_RST};
      cfg.green <= '{mask: GREEN_MASK_RST, shift: GREEN_SHIFT_RST};
      cfg.blue  <= '{mask: BLUE_MASK_RST,  shift: BLUE_SHIFT_RST};
    end else if (wr_en) begin
      case (wr_idx)
        REG_RED_MASK:   cfg.red   <= '{mask: pwdata, shift: wr_shift};
        REG_GREEN_MASK: cfg.green <= '{mask: pwdata, shift: wr_shift};
        REG_BLUE_MASK:  cfg.blue  <= '{mask: pwdata, shift: wr_shift};
        default: ;
      endcase
    end
  end

  // Read back the selected mask
  always_comb begin
    case (wr_idx)
      REG_RED_MASK:   prdata = cfg.red.mask;
      REG_GREEN_MASK: prdata = cfg.green.mask;
      REG_BLUE_MASK:  prdata = cfg.blue.mask;
      default:        prdata = 32'd0;
    endcase
  end

  // Advance a stage when the one after it is empty or being drained
  assign s2_en       = !pixels_valid || pixels_ready;
  assign s1_en       = !s1_valid || s2_en;
  assign block_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      pixels_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= block_valid;
      end
      if (s2_en) begin
        pixels_valid <= s1_valid;
      end
    end
  end

  // Stage one: shared chroma terms
  y2rgb_chroma u_chroma (
    .chroma_u (block.chroma_u),
    .chroma_v (block.chroma_v),
    .terms    (terms)
  );

  always_ff @(posedge clk) begin
    if (s1_en && block_valid) begin
      s1_terms   <= terms;
      s1_luma[0] <= block.luma_top_left;
      s1_luma[1] <= block.luma_top_right;
      s1_luma[2] <= block.luma_bottom_left;
      s1_luma[3] <= block.luma_bottom_right;
    end
  end

  // Stage two: one lane per pixel
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    y2rgb_lane u_lane (
      .luma  (s1_luma[g]),
      .terms (s1_terms),
      .cfg   (cfg),
      .pixel (lane_px[g])
    );
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      pixels.pixel_top_left     <= lane_px[0];
      pixels.pixel_top_right    <= lane_px[1];
      pixels.pixel_bottom_left  <= lane_px[2];
      pixels.pixel_bottom_right <= lane_px[3];
    end
  end

endmodule

// ===== rtl/y2rgb_checker.sv =====
module y2rgb_checker
  import y2rgb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic block_valid,
  input logic block_ready,
  input logic pixels_valid,
  input logic pixels_ready,
  input px_t  pixels
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixels_valid)
    else $error("result valid after reset");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pixels_valid |-> block_ready)
    else $error("input stalled with empty result register");

  // Draining the result always frees the input
  a_ready_on_drain: assert property (@(posedge clk) disable iff (rst)
    (pixels_valid && pixels_ready) |-> block_ready)
    else $error("input stalled while result drains");

  // An accepted item passes the stage-one registers and reaches the output when the output moves
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (block_valid && block_ready) ##1 pixels_ready |=> pixels_valid)
    else $error("accepted item did not reach the output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (pixels_valid && !pixels_ready) |=> (pixels_valid && $stable(pixels)))
    else $error("stalled result changed");

endmodule

bind yuv420_block_to_rgb_pack y2rgb_checker u_y2rgb_checker (
  .clk          (clk),
  .rst          (rst),
  .block_valid  (block_valid),
  .block_ready  (block_ready),
  .pixels_valid (pixels_valid),
  .pixels_ready (pixels_ready),
  .pixels       (pixels)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import y2rgb_pkg::*;

  localparam int UNUSED_REG_IDX = 3;    // one past the blue mask, writes are dropped
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RAND_PER_PHASE = 108;

  // Predicts the four packed pixels of each block and checks them in order
  class pixel_scoreboard;
    logic [31:0] mask_red, mask_grn, mask_blu;
    px_t         px_due_q[$];
    int          errors;
    int          blocks_in;
    int          pixels_out;

    function new();
      mask_red = RED_MASK_RST;
      mask_grn = GREEN_MASK_RST;
      mask_blu = BLUE_MASK_RST;
    endfunction

    function void set_mask(int idx, logic [31:0] val);
      if (idx == REG_RED_MASK) mask_red = val;
      else if (idx == REG_GREEN_MASK) mask_grn = val;
      else if (idx == REG_BLUE_MASK) mask_blu = val;
    endfunction

    function logic [7:0] clamp_chan(int x);
      if (x > 255) return 8'd255;
      if (x < 0) return 8'd0;
      return x[7:0];
    endfunction

    // Move the channel up to the mask's lowest set bit; a zero mask keeps shift 0
    function logic [31:0] place_chan(logic [7:0] c, logic [31:0] m);
      int          sh;
      logic [31:0] wide;
      sh = 0;
      if (m != 0) begin
        while (m[sh] == 1'b0) sh++;
      end
      wide = {24'd0, c};
      return (wide << sh) & m;
    endfunction

    function logic [31:0] to_pixel(logic [7:0] y, int du, int dv);
      int yy;
      logic [7:0] r, g, b;
      yy = int'(y);
      r = clamp_chan(yy + ((351 * dv) >>> 8));
      g = clamp_chan(yy - ((179 * dv + 86 * du) >>> 8));
      b = clamp_chan(yy + ((444 * du) >>> 8));
      return place_chan(r, mask_red) | place_chan(g, mask_grn) |
             place_chan(b, mask_blu);
    endfunction

    function void note_block(blk_t blk);
      int  du, dv;
      px_t px;
      du = int'(blk.chroma_u) - 128;
      dv = int'(blk.chroma_v) - 128;
      px.pixel_top_left     = to_pixel(blk.luma_top_left, du, dv);
      px.pixel_top_right    = to_pixel(blk.luma_top_right, du, dv);
      px.pixel_bottom_left  = to_pixel(blk.luma_bottom_left, du, dv);
      px.pixel_bottom_right = to_pixel(blk.luma_bottom_right, du, dv);
      px_due_q.push_back(px);
      blocks_in++;
    endfunction

    function void check_pixels(px_t got);
      px_t         want;
      logic [31:0] w [4];
      logic [31:0] g [4];
      string       names [4];
      pixels_out++;
      if (px_due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: pixels %h arrived with no block outstanding", $time, got);
        return;
      end
      want = px_due_q.pop_front();
      w = '{want.pixel_top_left, want.pixel_top_right,
            want.pixel_bottom_left, want.pixel_bottom_right};
      g = '{got.pixel_top_left, got.pixel_top_right,
            got.pixel_bottom_left, got.pixel_bottom_right};
      names = '{"pixel_top_left", "pixel_top_right",
                "pixel_bottom_left", "pixel_bottom_right"};
      foreach (w[i]) begin
        if (g[i] !== w[i]) begin
          errors++;
          if (errors <= 10)
            $display("%0t: %s expected %h got %h", $time, names[i], w[i], g[i]);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  block_valid;
  logic                  block_ready;
  blk_t                  block;
  logic                  pixels_valid;
  logic                  pixels_ready;
  px_t                   pixels;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  pixel_scoreboard sb = new();
  bit              hold_req;
  int              burst_left;

  yuv420_block_to_rgb_pack i_dut (
    .clk          (clk),
    .rst          (rst),
    .block_valid  (block_valid),
    .block_ready  (block_ready),
    .block        (block),
    .pixels_valid (pixels_valid),
    .pixels_ready (pixels_ready),
    .pixels       (pixels),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Note accepted blocks and check accepted pixels
  always @(posedge clk) begin
    if (!rst && block_valid && block_ready) sb.note_block(block);
    if (!rst && pixels_valid && pixels_ready) sb.check_pixels(pixels);
  end

  // Stall the result side in changing patterns, with one long hold-off on request
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    pixels_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pixels_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 64);
        end
        left--;
        case (mode)
          0: pixels_ready <= 1'b1;
          1: pixels_ready <= 1'($urandom_range(0, 1));
          2: pixels_ready <= ($urandom_range(0, 9) != 0);
          default: pixels_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Write one mask register through a setup and an access cycle
  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_mask(idx, val);
  endtask

  task automatic write_masks(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    write_reg(REG_RED_MASK, r);
    write_reg(REG_GREEN_MASK, g);
    write_reg(REG_BLUE_MASK, b);
  endtask

  // Offer one block and hold it until taken; at times drop valid between bursts
  task automatic send_block(blk_t blk);
    block       <= blk;
    block_valid <= 1'b1;
    do @(posedge clk); while (!block_ready);
    burst_left--;
    if (burst_left <= 0) begin
      int gap;
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        block_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid right after the last item, wait until every block has come back
  task automatic drain();
    block_valid <= 1'b0;
    while (sb.px_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chroma();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 15));
      1: return 8'($urandom_range(240, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_random(int n);
    blk_t blk;
    repeat (n) begin
      blk.luma_top_left     = 8'($urandom_range(0, 255));
      blk.luma_top_right    = 8'($urandom_range(0, 255));
      blk.luma_bottom_left  = 8'($urandom_range(0, 255));
      blk.luma_bottom_right = 8'($urandom_range(0, 255));
      blk.chroma_u          = rand_chroma();
      blk.chroma_v          = rand_chroma();
      send_block(blk);
    end
  endtask

  initial begin
    logic [7:0] chroma_pts [3];
    blk_t       blk;
    logic [31:0] rm, gm, bm;
    chroma_pts = '{8'd0, 8'd128, 8'd255};
    rst         <= 1'b1;
    block_valid <= 1'b0;
    block       <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    hold_req    = 1'b0;
    burst_left  = 4;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default masks: chroma corners against the luma extremes
    foreach (chroma_pts[u]) begin
      foreach (chroma_pts[v]) begin
        blk.luma_top_left     = 8'd0;
        blk.luma_top_right    = 8'd255;
        blk.luma_bottom_left  = 8'd1;
        blk.luma_bottom_right = 8'd254;
        blk.chroma_u          = chroma_pts[u];
        blk.chroma_v          = chroma_pts[v];
        send_block(blk);
      end
    end
    blk = '{8'd128, 8'd127, 8'd16, 8'd235, 8'd127, 8'd129};
    send_block(blk);
    blk = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    send_block(blk);
    blk = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_block(blk);
    run_random(RAND_PER_PHASE);
    drain();

    // Overlapping full masks; a write past the last register must be dropped
    write_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(UNUSED_REG_IDX, 32'hDEAD_BEEF);
    blk = '{8'd255, 8'd0, 8'd128, 8'd64, 8'd0, 8'd255};
    send_block(blk);
    run_random(RAND_PER_PHASE);
    drain();

    // Zero mask, mask with gaps, channel pushed past bit 31; stall the output long
    write_masks(32'h0000_0000, 32'h0000_0F0F, 32'h8000_0000);
    hold_req = 1'b1;
    run_random(RAND_PER_PHASE);
    drain();

    // Top-byte red, single-bit green, blue placed mid-word
    write_masks(32'hFF00_0000, 32'h0000_0001, 32'h0001_FE00);
    run_random(RAND_PER_PHASE / 2);
    drain();
    // 5-6-5 layout
    write_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
    run_random(RAND_PER_PHASE / 2);
    drain();

    // Random masks, now and then zero
    repeat (4) begin
      rm = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
      gm = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
      bm = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
      write_masks(rm, gm, bm);
      run_random(RAND_PER_PHASE / 4);
      drain();
    end

    $display("Run covered %0d blocks, %0d pixel items checked, %0d mismatches",
             sb.blocks_in, sb.pixels_out, sb.errors);
    $display("Mask setups: defaults, full, zero/gapped/bit31, narrow, 5-6-5, random");
    if (sb.errors == 0 && sb.px_due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
